[sv/mbrtu_pkg.sv]
package mbrtu_pkg;

	// Request kinds
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_BYTE  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_TIMEOUT = 2'd1;
	localparam logic [1:0] STAT_CRC     = 2'd2;
	localparam logic [1:0] STAT_HEADER  = 2'd3;

	// Configuration register indexes
	localparam logic CFG_DEVICE_ADDRESS = 1'b0;
	localparam logic CFG_TIMEOUT_TICKS  = 1'b1;

	localparam logic [7:0]  ADDR_RESET      = 8'd1;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd300;
	localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
	localparam logic [15:0] CRC_INIT        = 16'hFFFF;
	localparam logic [15:0] CRC_POLY        = 16'hA001;
	localparam logic [15:0] TICKS_MAX       = 16'hFFFF;
	localparam int          HDR_BYTES       = 5;
	localparam int          RESPONSE_BYTES_DEF = 32;

	// Buffer port address width covers the largest supported buffer
	localparam int BUF_AW_MAX = 8;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] start_register;
		logic [3:0]  register_count;
		logic [7:0]  rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] data_byte;
		logic [1:0] status_code;
		logic       last_of_run;
	} rsp_t;

	typedef struct packed {
		logic                  en;
		logic [BUF_AW_MAX-1:0] addr;
		logic [7:0]            data;
	} buf_wr_t;

	typedef struct packed {
		logic                  en;
		logic [BUF_AW_MAX-1:0] addr;
	} buf_rd_t;

	// CRC-16 (reflected 0xA001) over one byte
	function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

[sv/mbrtu_resp_buf.sv]
module mbrtu_resp_buf #(
	parameter int RESPONSE_BYTES = mbrtu_pkg::RESPONSE_BYTES_DEF
) (
	input  logic              clk,
	input  mbrtu_pkg::buf_wr_t wr,
	input  mbrtu_pkg::buf_rd_t rd,
	output logic [7:0]        rd_data
);
	import mbrtu_pkg::*;

	localparam int AW = $clog2(RESPONSE_BYTES);

	logic [7:0] mem [RESPONSE_BYTES];

	// Single write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[AW-1:0]] <= wr.data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr[AW-1:0]];
		end
	end

endmodule

[sv/modbus_rtu_read_input_master_core.sv]
// Modbus RTU master for function 04 (read input registers). A start item
// produces the 8-byte request frame, one transmit byte per cycle unless the
// output stalls, with the CRC-16 built byte by byte as the frame goes out; the
// core is busy until the frame is out. While waiting, each received byte or
// tick is one input item; a status item follows when it ends the transaction.
// On the last response byte the core checks CRC, address, function code and
// byte count; on success it reads the payload back from the response buffer
// (a registered read, then one byte per cycle unless the output stalls),
// followed by the status item. Output stalls stretch all of these.
// register_count is saturated to what the buffer can hold.
module modbus_rtu_read_input_master_core #(
	parameter int RESPONSE_BYTES = mbrtu_pkg::RESPONSE_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  mbrtu_pkg::req_t in_item,
	output logic            out_valid,
	input  logic            out_stall,
	output mbrtu_pkg::rsp_t out_item,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [15:0]     cfg_data
);
	import mbrtu_pkg::*;

	localparam int CNT_W   = $clog2(RESPONSE_BYTES + 1);
	localparam int MAX_RAW = (RESPONSE_BYTES - HDR_BYTES) / 2;
	localparam logic [3:0] MAX_CNT = (MAX_RAW > 15) ? 4'd15 : 4'(MAX_RAW);

	// Sequencer codes
	localparam logic [2:0] SQ_READY = 3'd0;
	localparam logic [2:0] SQ_TX    = 3'd1;
	localparam logic [2:0] SQ_RDA   = 3'd2;
	localparam logic [2:0] SQ_RDD   = 3'd3;
	localparam logic [2:0] SQ_STAT  = 3'd4;

	// Control state
	logic [2:0]       seq_q, seq_d;
	logic             phase_q, phase_d;
	logic [15:0]      crc_q, crc_d;
	logic [CNT_W-1:0] rcv_q, rcv_d;
	logic [3:0]       exp_q, exp_d;
	logic [15:0]      elapsed_q, elapsed_d;
	logic [2:0]       tx_idx_q, tx_idx_d;
	logic [CNT_W-1:0] ptr_q, ptr_d;
	logic [7:0]       dev_addr_q;
	logic [15:0]      timeout_q;
	logic             out_valid_q;

	// Payload state
	logic [1:0]  status_q, status_d;
	logic [15:0] sreg_q, sreg_d;
	logic [7:0]  addr_byte_q, addr_byte_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic        hdr_ok_q, hdr_ok_d;
	rsp_t        out_q, out_d;
	logic        out_load;

	buf_wr_t     wr;
	buf_rd_t     rd;
	logic [7:0]  buf_rdata;

	logic             accept;
	logic             slot_free;
	logic [CNT_W-1:0] resp_len;
	logic [CNT_W-1:0] last_ptr;
	logic [3:0]       sat_cnt;
	logic [15:0]      tick_nx;
	logic [7:0]       tx_byte;
	logic [7:0]       rxb;
	logic             crc_ok;
	logic             hdr_ok;

	assign in_stall  = (seq_q != SQ_READY);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign resp_len = CNT_W'(HDR_BYTES) + (CNT_W'(exp_q) << 1);
	assign last_ptr = CNT_W'(2) + (CNT_W'(exp_q) << 1);
	assign sat_cnt  = (in_item.register_count > MAX_CNT) ? MAX_CNT : in_item.register_count;
	assign tick_nx  = (elapsed_q != TICKS_MAX) ? elapsed_q + 16'd1 : elapsed_q;
	assign rxb      = in_item.rx_byte;
	assign crc_ok   = (crc_lo_q == crc_q[7:0]) && (rxb == crc_q[15:8]);
	assign hdr_ok   = hdr_ok_q && (addr_byte_q == dev_addr_q);

	// Request frame byte mux
	always_comb begin
		case (tx_idx_q)
			3'd0:    tx_byte = dev_addr_q;
			3'd1:    tx_byte = FUNC_READ_INPUT;
			3'd2:    tx_byte = sreg_q[15:8];
			3'd3:    tx_byte = sreg_q[7:0];
			3'd4:    tx_byte = 8'h00;
			3'd5:    tx_byte = {4'h0, exp_q};
			3'd6:    tx_byte = crc_q[7:0];
			default: tx_byte = crc_q[15:8];
		endcase
	end

	// Sequencer and transaction bookkeeping
	always_comb begin
		seq_d       = seq_q;
		phase_d     = phase_q;
		crc_d       = crc_q;
		rcv_d       = rcv_q;
		exp_d       = exp_q;
		elapsed_d   = elapsed_q;
		tx_idx_d    = tx_idx_q;
		ptr_d       = ptr_q;
		status_d    = status_q;
		sreg_d      = sreg_q;
		addr_byte_d = addr_byte_q;
		crc_lo_d    = crc_lo_q;
		hdr_ok_d    = hdr_ok_q;
		out_load    = 1'b0;
		out_d       = '0;
		wr          = '0;
		rd          = '0;

		unique case (seq_q)
			SQ_READY: begin
				if (accept) begin
					if (in_item.req_type == REQ_START) begin
						sreg_d    = in_item.start_register;
						exp_d     = sat_cnt;
						crc_d     = CRC_INIT;
						rcv_d     = '0;
						elapsed_d = '0;
						tx_idx_d  = '0;
						phase_d   = 1'b1;
						seq_d     = SQ_TX;
					end else if (phase_q && in_item.req_type == REQ_TICK) begin
						elapsed_d = tick_nx;
						if (tick_nx >= timeout_q) begin
							phase_d  = 1'b0;
							status_d = STAT_TIMEOUT;
							seq_d    = SQ_STAT;
						end
					end else if (phase_q && in_item.req_type == REQ_BYTE) begin
						if (rcv_q >= resp_len) begin
							phase_d = 1'b0;
						end else begin
							wr.en   = 1'b1;
							wr.addr = BUF_AW_MAX'(rcv_q);
							wr.data = rxb;
							rcv_d   = rcv_q + CNT_W'(1);
							if (rcv_q < resp_len - CNT_W'(2)) begin
								crc_d = crc_feed(crc_q, rxb);
							end
							if (rcv_q == resp_len - CNT_W'(2)) begin
								crc_lo_d = rxb;
							end
							if (rcv_q == CNT_W'(0)) begin
								addr_byte_d = rxb;
							end
							if (rcv_q == CNT_W'(1)) begin
								hdr_ok_d = (rxb == FUNC_READ_INPUT);
							end
							if (rcv_q == CNT_W'(2)) begin
								hdr_ok_d = hdr_ok_q && (rxb == {3'b000, exp_q, 1'b0});
							end
							// Last byte: run the checks
							if (rcv_q == resp_len - CNT_W'(1)) begin
								phase_d = 1'b0;
								if (!crc_ok) begin
									status_d = STAT_CRC;
									seq_d    = SQ_STAT;
								end else if (!hdr_ok) begin
									status_d = STAT_HEADER;
									seq_d    = SQ_STAT;
								end else begin
									status_d = STAT_OK;
									ptr_d    = CNT_W'(3);
									seq_d    = (exp_q == 4'd0) ? SQ_STAT : SQ_RDA;
								end
							end
						end
					end
				end
			end
			SQ_TX: begin
				if (slot_free) begin
					out_load          = 1'b1;
					out_d.out_kind    = KIND_TX;
					out_d.data_byte   = tx_byte;
					out_d.last_of_run = (tx_idx_q == 3'd7);
					if (tx_idx_q < 3'd6) begin
						crc_d = crc_feed(crc_q, tx_byte);
					end
					tx_idx_d = tx_idx_q + 3'd1;
					if (tx_idx_q == 3'd7) begin
						crc_d = CRC_INIT;
						seq_d = SQ_READY;
					end
				end
			end
			SQ_RDA: begin
				rd.en   = 1'b1;
				rd.addr = BUF_AW_MAX'(ptr_q);
				seq_d   = SQ_RDD;
			end
			SQ_RDD: begin
				if (slot_free) begin
					out_load        = 1'b1;
					out_d.out_kind  = KIND_DATA;
					out_d.data_byte = buf_rdata;
					if (ptr_q == last_ptr) begin
						seq_d = SQ_STAT;
					end else begin
						ptr_d   = ptr_q + CNT_W'(1);
						rd.en   = 1'b1;
						rd.addr = BUF_AW_MAX'(ptr_q + CNT_W'(1));
					end
				end
			end
			SQ_STAT: begin
				if (slot_free) begin
					out_load          = 1'b1;
					out_d.out_kind    = KIND_STATUS;
					out_d.status_code = status_q;
					out_d.last_of_run = 1'b1;
					seq_d             = SQ_READY;
				end
			end
			default: begin
				seq_d = SQ_READY;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= SQ_READY;
			phase_q     <= 1'b0;
			crc_q       <= CRC_INIT;
			rcv_q       <= '0;
			exp_q       <= '0;
			elapsed_q   <= '0;
			tx_idx_q    <= '0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			seq_q     <= seq_d;
			phase_q   <= phase_d;
			crc_q     <= crc_d;
			rcv_q     <= rcv_d;
			exp_q     <= exp_d;
			elapsed_q <= elapsed_d;
			tx_idx_q  <= tx_idx_d;
			ptr_q     <= ptr_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= ADDR_RESET;
			timeout_q  <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_data[7:0];
				CFG_TIMEOUT_TICKS:  timeout_q  <= cfg_data;
				default:            dev_addr_q <= dev_addr_q;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		status_q    <= status_d;
		sreg_q      <= sreg_d;
		addr_byte_q <= addr_byte_d;
		crc_lo_q    <= crc_lo_d;
		hdr_ok_q    <= hdr_ok_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	mbrtu_resp_buf #(
		.RESPONSE_BYTES(RESPONSE_BYTES)
	) u_buf (
		.clk    (clk),
		.wr     (wr),
		.rd     (rd),
		.rd_data(buf_rdata)
	);

	// Checks
	a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.en && rd.en))
		else $error("response buffer written and read in one cycle");

	a_rd_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SQ_RDA || seq_q == SQ_RDD) |-> !phase_q)
		else $error("payload readout while response still pending");

	a_start_goes_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_item.req_type == REQ_START) |=> (seq_q == SQ_TX))
		else $error("start request did not begin frame transmit");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.out_kind == KIND_STATUS) |->
		(out_q.data_byte == 8'h00 && out_q.last_of_run))
		else $error("malformed status item");

	a_data_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.out_kind == KIND_DATA) |-> !out_q.last_of_run)
		else $error("payload byte marked last");

endmodule
